@@ rtl/iirdf1_pkg.sv @@
// Shared types, constants and register indexes of the direct-form-I IIR filter.
`timescale 1ns / 1ps

package iirdf1_pkg;

   // Filter order, sample width and coefficient format.
   localparam int ORDER          = 3;
   localparam int SAMPLE_WIDTH   = 16;
   localparam int COEF_FRAC_BITS = 14;
   localparam int COEF_WIDTH     = 18;

   // History depth kept in registers, and the number of taps that take part.
   localparam int DEPTH = 3;
   localparam int TAPS  = (ORDER > DEPTH) ? DEPTH : ((ORDER < 1) ? 1 : ORDER);

   // One product of a coefficient and a sample, and the accumulator that holds
   // up to eight such products without overflow.
   localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + 3;

   // Configuration register indexes.
   localparam int REG_INDEX_WIDTH = 3;

   typedef logic signed [SAMPLE_WIDTH-1:0]  sample_type;
   typedef logic signed [COEF_WIDTH-1:0]    coef_type;
   typedef logic signed [PROD_WIDTH-1:0]    prod_type;
   typedef logic signed [ACC_WIDTH-1:0]     acc_type;
   typedef logic [REG_INDEX_WIDTH-1:0]      reg_index_type;

   localparam reg_index_type REG_FF_COEF_0 = reg_index_type'(0);
   localparam reg_index_type REG_FF_COEF_1 = reg_index_type'(1);
   localparam reg_index_type REG_FF_COEF_2 = reg_index_type'(2);
   localparam reg_index_type REG_FF_COEF_3 = reg_index_type'(3);
   localparam reg_index_type REG_FB_COEF_1 = reg_index_type'(4);
   localparam reg_index_type REG_FB_COEF_2 = reg_index_type'(5);
   localparam reg_index_type REG_FB_COEF_3 = reg_index_type'(6);

   // Unity gain in the coefficient format, the reset value of b0.
   localparam coef_type COEF_ONE = coef_type'(1) <<< COEF_FRAC_BITS;

   // Half an output step for round half up, and the saturation limits.
   localparam acc_type ROUND_BIAS = acc_type'(1) <<< (COEF_FRAC_BITS - 1);
   localparam acc_type SAT_HI     = (acc_type'(1) <<< (SAMPLE_WIDTH - 1)) - acc_type'(1);
   localparam acc_type SAT_LO     = -(acc_type'(1) <<< (SAMPLE_WIDTH - 1));

   // Shift strobes handed to every cell of the history chain.
   typedef struct packed {
      logic shift_x;
      logic shift_y;
   } cell_ctrl_type;

endpackage

@@ rtl/iirdf1_cell.sv @@
// One tap cell: holds one past input and one past output and forms both products.
`timescale 1ns / 1ps

module iirdf1_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  iirdf1_pkg::cell_ctrl_type ctrl,
   input  iirdf1_pkg::sample_type    x_in,
   input  iirdf1_pkg::sample_type    y_in,
   input  iirdf1_pkg::coef_type      b_coef,
   input  iirdf1_pkg::coef_type      a_coef,
   output iirdf1_pkg::sample_type    x_out,
   output iirdf1_pkg::sample_type    y_out,
   output iirdf1_pkg::prod_type      ff_prod,
   output iirdf1_pkg::prod_type      fb_prod
);

   import iirdf1_pkg::*;

   sample_type x_ff;
   sample_type x_in_d;
   sample_type y_ff;
   sample_type y_in_d;

   // Take the neighbour's sample on a shift, otherwise hold.
   assign x_in_d = ctrl.shift_x ? x_in : x_ff;
   assign y_in_d = ctrl.shift_y ? y_in : y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
      end else begin
         x_ff <= x_in_d;
         y_ff <= y_in_d;
      end
   end

   // Products of this tap, both exact at product width.
   assign ff_prod = prod_type'(b_coef) * prod_type'(x_ff);
   assign fb_prod = prod_type'(a_coef) * prod_type'(y_ff);

   assign x_out = x_ff;
   assign y_out = y_ff;

endmodule

@@ rtl/iir_filter_direct_form_one_unit.sv @@
// Top level of the direct-form-I IIR filter: coefficient registers, tap chain and output stage.
`timescale 1ns / 1ps

// Direct-form-I IIR filter of order three on signed 16-bit samples with signed Q4.14
// coefficients. It accepts one sample per clock cycle unless rsp_ready stalls the output;
// the sum is registered in stage one and the result in the output register, where it waits
// while rsp_ready is low. The first stage adds the feed-forward products of the new sample
// and the input history; the second subtracts the feedback products of the output history,
// rounds half up, saturates and pushes the result into the history. That second stage, from
// the output history through the three feedback multipliers, the adder, rounding and
// saturation back into the history, is combinational and sets the rate of one sample a cycle.
// The user must write coefficients through the csr_ port only while the filter is idle; the
// block does not enforce it. An index above six is ignored. The history is zero after reset.
module iir_filter_direct_form_one_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  iirdf1_pkg::reg_index_type     csr_index,
   input  iirdf1_pkg::coef_type          csr_write_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  iirdf1_pkg::sample_type        req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output iirdf1_pkg::sample_type        rsp_sample_out,
   output logic                          rsp_clipped
);

   import iirdf1_pkg::*;

   coef_type      feed_fwd_ff [0:DEPTH];
   coef_type      feedback_ff [1:DEPTH];

   logic          s1_valid_ff;
   logic          s1_valid_in;
   acc_type       s1_sum_ff;
   acc_type       s1_sum_in;

   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   sample_type    rsp_sample_ff;
   logic          rsp_clipped_ff;

   logic          req_fire;
   logic          s2_fire;
   cell_ctrl_type cell_ctrl;

   sample_type    x_chain [0:TAPS];
   sample_type    y_chain [0:TAPS];
   prod_type      ff_prod [1:TAPS];
   prod_type      fb_prod [1:TAPS];
   prod_type      lead_prod;

   acc_type       acc;
   acc_type       rounded;
   sample_type    y_new;
   logic          clip_new;

   // Coefficient registers; writes beyond the last register are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         feed_fwd_ff[0] <= COEF_ONE;
         for (int k = 1; k <= DEPTH; k++) begin
            feed_fwd_ff[k] <= '0;
            feedback_ff[k] <= '0;
         end
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_FF_COEF_0: begin
               feed_fwd_ff[0] <= csr_write_data;
            end
            REG_FF_COEF_1: begin
               feed_fwd_ff[1] <= csr_write_data;
            end
            REG_FF_COEF_2: begin
               feed_fwd_ff[2] <= csr_write_data;
            end
            REG_FF_COEF_3: begin
               feed_fwd_ff[3] <= csr_write_data;
            end
            REG_FB_COEF_1: begin
               feedback_ff[1] <= csr_write_data;
            end
            REG_FB_COEF_2: begin
               feedback_ff[2] <= csr_write_data;
            end
            REG_FB_COEF_3: begin
               feedback_ff[3] <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Handshake: the second stage moves when it holds a sum and the output register is free or drained.
   assign s2_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s2_fire;
   assign req_fire  = req_valid && req_ready;

   assign cell_ctrl.shift_x = req_fire;
   assign cell_ctrl.shift_y = s2_fire;

   // The history chain: the new sample and the new result enter at the head.
   assign x_chain[0] = req_sample_in;
   assign y_chain[0] = y_new;

   for (genvar k = 1; k <= TAPS; k++) begin : g_cell
      iirdf1_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (cell_ctrl),
         .x_in    (x_chain[k-1]),
         .y_in    (y_chain[k-1]),
         .b_coef  (feed_fwd_ff[k]),
         .a_coef  (feedback_ff[k]),
         .x_out   (x_chain[k]),
         .y_out   (y_chain[k]),
         .ff_prod (ff_prod[k]),
         .fb_prod (fb_prod[k])
      );
   end

   // First stage: feed-forward sum of the new sample and the input history.
   assign lead_prod = prod_type'(feed_fwd_ff[0]) * prod_type'(req_sample_in);

   always_comb begin
      s1_sum_in = acc_type'(lead_prod);
      for (int k = 1; k <= TAPS; k++) begin
         s1_sum_in = s1_sum_in + acc_type'(ff_prod[k]);
      end
   end

   // Second stage: subtract the feedback terms, round half up and saturate.
   always_comb begin
      acc = s1_sum_ff + ROUND_BIAS;
      for (int k = 1; k <= TAPS; k++) begin
         acc = acc - acc_type'(fb_prod[k]);
      end
      rounded = acc >>> COEF_FRAC_BITS;
      if (rounded > SAT_HI) begin
         y_new    = sample_type'(SAT_HI);
         clip_new = 1'b1;
      end else if (rounded < SAT_LO) begin
         y_new    = sample_type'(SAT_LO);
         clip_new = 1'b1;
      end else begin
         y_new    = sample_type'(rounded);
         clip_new = 1'b0;
      end
   end

   // Stage valid flags.
   assign s1_valid_in  = req_fire || (s1_valid_ff && !s2_fire);
   assign rsp_valid_in = s2_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers of both stages.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_sum_ff <= s1_sum_in;
      end
      if (s2_fire) begin
         rsp_sample_ff  <= y_new;
         rsp_clipped_ff <= clip_new;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clipped_ff;

endmodule

@@ tb/sv/iir_filter_direct_form_one_unit_tb.sv @@
// Self-checking testbench for the direct-form-I IIR filter unit.
`timescale 1ns / 1ps

module iir_filter_direct_form_one_unit_tb;
   import iirdf1_pkg::*;

   // Index with no register behind it; a write there must change nothing.
   localparam reg_index_type REG_UNUSED = reg_index_type'(7);
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_PHASES = 14;
   localparam int unsigned IDLE_PERCENT = 21;

   typedef struct {
      sample_type sample_out;
      logic       clipped;
   } filter_result_type;

   // Holds its own copy of the coefficients and history and predicts every output beat.
   class iir_scoreboard;
      coef_type          ff_coef [4];
      coef_type          fb_coef [4];
      sample_type        past_x [DEPTH];
      sample_type        past_y [DEPTH];
      filter_result_type pending_results [$];
      int unsigned       mismatches;
      int unsigned       checked;
      int unsigned       clip_count;

      function new();
         for (int k = 0; k < 4; k++) begin
            ff_coef[k] = '0;
            fb_coef[k] = '0;
         end
         ff_coef[0] = COEF_ONE;
         for (int k = 0; k < DEPTH; k++) begin
            past_x[k] = '0;
            past_y[k] = '0;
         end
         mismatches = 0;
         checked    = 0;
         clip_count = 0;
      endfunction

      function void write_coef(reg_index_type idx, coef_type val);
         case (idx)
            REG_FF_COEF_0: ff_coef[0] = val;
            REG_FF_COEF_1: ff_coef[1] = val;
            REG_FF_COEF_2: ff_coef[2] = val;
            REG_FF_COEF_3: ff_coef[3] = val;
            REG_FB_COEF_1: fb_coef[1] = val;
            REG_FB_COEF_2: fb_coef[2] = val;
            REG_FB_COEF_3: fb_coef[3] = val;
            default: ;
         endcase
      endfunction

      // Forms the exact sum, rounds half up, saturates and shifts the history.
      function void note_input(sample_type x);
         longint            acc;
         longint            y_wide;
         longint            sat_hi;
         longint            sat_lo;
         filter_result_type res;
         acc    = longint'(ff_coef[0]) * longint'(x);
         sat_hi = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
         sat_lo = -sat_hi - 1;
         for (int k = 1; k <= TAPS; k++) begin
            acc = acc + longint'(ff_coef[k]) * longint'(past_x[k-1]);
            acc = acc - longint'(fb_coef[k]) * longint'(past_y[k-1]);
         end
         acc    = acc + (longint'(1) <<< (COEF_FRAC_BITS - 1));
         y_wide = acc >>> COEF_FRAC_BITS;
         res.clipped = 1'b0;
         if (y_wide > sat_hi) begin
            y_wide      = sat_hi;
            res.clipped = 1'b1;
         end else if (y_wide < sat_lo) begin
            y_wide      = sat_lo;
            res.clipped = 1'b1;
         end
         res.sample_out = sample_type'(y_wide);
         if (res.clipped) begin
            clip_count++;
         end
         for (int k = DEPTH - 1; k > 0; k--) begin
            past_x[k] = past_x[k-1];
            past_y[k] = past_y[k-1];
         end
         past_x[0] = x;
         past_y[0] = res.sample_out;
         pending_results.push_back(res);
      endfunction

      function void check_result(sample_type y, logic clip);
         filter_result_type want;
         if (pending_results.size() == 0) begin
            $error("Output beat with no prediction waiting: sample_out %0d, clipped %0b",
                   y, clip);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (y !== want.sample_out) begin
            $error("sample_out mismatch: expected %0d, actual %0d", want.sample_out, y);
            mismatches++;
         end
         if (clip !== want.clipped) begin
            $error("clipped mismatch: expected %0b, actual %0b", want.clipped, clip);
            mismatches++;
         end
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          csr_write_enable;
   reg_index_type csr_index;
   coef_type      csr_write_data;
   logic          req_valid;
   logic          req_ready;
   sample_type    req_sample_in;
   logic          rsp_valid;
   logic          rsp_ready;
   sample_type    rsp_sample_out;
   logic          rsp_clipped;

   iir_scoreboard filter_board;
   bit            no_idle;
   int unsigned   cycle_count;
   int unsigned   samples_sent;
   int unsigned   settings_used;

   iir_filter_direct_form_one_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_clipped      (rsp_clipped)
   );

   // Free-running clock, 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The receiver stalls at random except during the stretch without idling.
   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Input beats feed the prediction; output beats are checked against it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            filter_board.note_input(req_sample_in);
         end
         if (rsp_valid && rsp_ready) begin
            filter_board.check_result(rsp_sample_out, rsp_clipped);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Writes all seven coefficients, and optionally the unused index, one per cycle.
   task automatic program_filter(input coef_type b0, input coef_type b1, input coef_type b2,
                                 input coef_type b3, input coef_type a1, input coef_type a2,
                                 input coef_type a3, input bit touch_unused);
      reg_index_type idx [8];
      coef_type      val [8];
      int            count;
      idx = '{REG_FF_COEF_0, REG_FF_COEF_1, REG_FF_COEF_2, REG_FF_COEF_3,
              REG_FB_COEF_1, REG_FB_COEF_2, REG_FB_COEF_3, REG_UNUSED};
      val = '{b0, b1, b2, b3, a1, a2, a3, coef_type'($urandom)};
      count = touch_unused ? 8 : 7;
      for (int i = 0; i < count; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= idx[i];
         csr_write_data   <= val[i];
         filter_board.write_coef(idx[i], val[i]);
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // Offers one sample, with a random gap ahead of it, and waits for the beat.
   task automatic send_sample(input sample_type x);
      while (!no_idle && ($urandom_range(99) < IDLE_PERCENT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      samples_sent++;
   endtask

   // Holds the sender back until every predicted output has come out.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (filter_board.pending() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   function automatic coef_type pick_coef(input int mode, input bit feedback);
      int v;
      v = 0;
      case (mode)
         0: return coef_type'($urandom);
         1: begin
            if (feedback) begin
               v = int'($urandom_range(0, 8192)) - 4096;
            end else begin
               v = int'($urandom_range(0, 32768)) - 16384;
            end
            return coef_type'(v);
         end
         default: begin
            case ($urandom_range(0, 5))
               0: return coef_type'(-131072);
               1: return coef_type'(131071);
               2: return coef_type'(0);
               3: return COEF_ONE;
               4: return -COEF_ONE;
               default: return coef_type'(1);
            endcase
         end
      endcase
   endfunction

   function automatic sample_type pick_sample();
      int r;
      r = int'($urandom_range(0, 9));
      if (r < 5) begin
         return sample_type'($urandom);
      end else if (r < 8) begin
         return sample_type'(int'($urandom_range(0, 1024)) - 512);
      end
      case ($urandom_range(0, 4))
         0: return sample_type'(-32768);
         1: return sample_type'(32767);
         2: return sample_type'(0);
         3: return sample_type'(-1);
         default: return sample_type'(1);
      endcase
   endfunction

   initial begin
      int  n_items;
      int  mode;
      int  b_mode [4];
      int  a_mode [4];
      bit  fir;
      filter_board     = new();
      no_idle          = 1'b0;
      cycle_count      = 0;
      samples_sent     = 0;
      settings_used    = 0;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= REG_FF_COEF_0;
      csr_write_data   <= '0;
      req_valid        <= 1'b0;
      req_sample_in    <= '0;
      rsp_ready        <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset coefficients pass samples through: zero history, full-scale inputs.
      send_sample(sample_type'(0));
      send_sample(sample_type'(32767));
      send_sample(sample_type'(-32768));
      send_sample(sample_type'(-1));
      send_sample(sample_type'(1));
      drain_pipeline();

      // Gain of one half shows round half up on odd samples of both signs.
      program_filter(coef_type'(8192), '0, '0, '0, '0, '0, '0, 1'b1);
      send_sample(sample_type'(1));
      send_sample(sample_type'(-1));
      send_sample(sample_type'(3));
      send_sample(sample_type'(-3));
      drain_pipeline();

      // Plain FIR at the coefficient extremes drives the output into saturation.
      program_filter(coef_type'(131071), coef_type'(-131072), coef_type'(131071),
                     coef_type'(-131072), '0, '0, '0, 1'b0);
      send_sample(sample_type'(32767));
      send_sample(sample_type'(-32768));
      send_sample(sample_type'(32767));
      send_sample(sample_type'(-32768));
      drain_pipeline();

      // An integrator saturates and feeds the clipped value back.
      program_filter(COEF_ONE, '0, '0, '0, -COEF_ONE, '0, '0, 1'b0);
      repeat (3) send_sample(sample_type'(30000));
      repeat (3) send_sample(sample_type'(-32768));
      drain_pipeline();

      // Every coefficient at an extreme, feedback included.
      program_filter(coef_type'(131071), coef_type'(131071), coef_type'(-131072),
                     coef_type'(131071), coef_type'(-131072), coef_type'(131071),
                     coef_type'(-131072), 1'b1);
      send_sample(sample_type'(-32768));
      send_sample(sample_type'(32767));
      send_sample(sample_type'(0));
      send_sample(sample_type'(0));
      drain_pipeline();

      // Random settings, each followed by a stream of random samples.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         mode = int'($urandom_range(0, 3));
         fir  = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < 4; k++) begin
            b_mode[k] = (mode == 3) ? int'($urandom_range(0, 2)) : mode;
            a_mode[k] = (mode == 3) ? int'($urandom_range(0, 2)) : mode;
         end
         program_filter(pick_coef(b_mode[0], 1'b0), pick_coef(b_mode[1], 1'b0),
                        pick_coef(b_mode[2], 1'b0), pick_coef(b_mode[3], 1'b0),
                        fir ? coef_type'(0) : pick_coef(a_mode[1], 1'b1),
                        fir ? coef_type'(0) : pick_coef(a_mode[2], 1'b1),
                        fir ? coef_type'(0) : pick_coef(a_mode[3], 1'b1),
                        ($urandom_range(0, 1) == 1));
         no_idle = (p == 6);
         n_items = int'($urandom_range(90, 118));
         for (int i = 0; i < n_items; i++) begin
            send_sample(pick_sample());
         end
         drain_pipeline();
         no_idle = 1'b0;
      end

      repeat (8) @(posedge clock);
      if (filter_board.pending() != 0) begin
         $error("%0d predicted outputs never arrived", filter_board.pending());
         filter_board.mismatches++;
      end
      $display("Sent %0d samples under %0d coefficient settings; %0d outputs checked.",
               samples_sent, settings_used, filter_board.checked);
      $display("Of those, %0d were saturated; %0d field mismatches were found.",
               filter_board.clip_count, filter_board.mismatches);
      if (filter_board.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ iir_filter_direct_form_one_unit.f @@
rtl/iirdf1_pkg.sv
rtl/iirdf1_cell.sv
rtl/iir_filter_direct_form_one_unit.sv
tb/sv/iir_filter_direct_form_one_unit_tb.sv
